@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the life grid block.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LGS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
`define LGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define LGS_ASSERT(lbl, clk, rst_n, prop)
`define LGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/lgs_pkg.sv @@
// Grid sizes, derived widths, row type and command codes of the life grid block.
// Depends on nothing.
package lgs_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;

    localparam int ROW_AW = $clog2(GRID_ROWS);
    localparam int COL_AW = $clog2(GRID_COLS);
    localparam int STEP_W = $clog2(GRID_ROWS + 1);

    typedef logic [GRID_COLS-1:0] t_row;
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_WRITE   = 2'd0;
    localparam t_cmd CMD_READ    = 2'd1;
    localparam t_cmd CMD_ADVANCE = 2'd2;
    localparam t_cmd CMD_UNUSED  = 2'd3;

endpackage

@@ src/life_grid_generation_step.sv @@
// Life grid block: a 64 by 64 B3/S23 grid stored one row per memory word.
// Cell write or read inside the grid: grid read register, then output register.
// Others load the output register; advance reads one row per cycle from the grid memory.
// One transaction is in work at a time; the next is taken once the output register is free.
// Reset clears the per-row valid flags, so the grid reads all dead at once; no clearing pass.
// Depends on lgs_pkg, lgs_row_rule and assert_macros.svh.
`include "assert_macros.svh"

module life_grid_generation_step import lgs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [5:0] i_row_index,
    input  logic [5:0] i_col_index,
    input  logic       i_cell_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_cell_out,
    output logic [1:0] o_done_kind
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ACCESS = 2'd1;
    localparam logic [1:0] S_ADV    = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    t_cmd              r_cmd;
    logic [ROW_AW-1:0] r_row;
    logic [COL_AW-1:0] r_col;
    logic              r_cell;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_row              r_win_top;
    t_row              r_win_mid;
    t_row              n_win_top;
    t_row              n_win_mid;

    t_row              r_grid [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_row_live;
    t_row              r_rd_data;
    logic              r_rd_live;

    logic              r_out_valid;
    logic              r_out_cell;
    t_cmd              r_out_kind;

    logic              accept;
    logic              in_grid;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    t_row              wr_data;
    t_row              rd_row;
    t_row              adv_below;
    t_row              adv_next;
    logic              load;
    logic              load_cell;
    t_cmd              load_kind;

    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign accept      = i_valid && o_ready;
    assign in_grid     = (int'(i_row_index) < GRID_ROWS) && (int'(i_col_index) < GRID_COLS);
    assign rd_row      = r_rd_live ? r_rd_data : '0;
    assign adv_below   = (r_step < STEP_W'(GRID_ROWS)) ? rd_row : '0;
    assign o_valid     = r_out_valid;
    assign o_cell_out  = r_out_cell;
    assign o_done_kind = r_out_kind;

    lgs_row_rule u_rule (
        .i_above (r_win_top),
        .i_mid   (r_win_mid),
        .i_below (adv_below),
        .o_next  (adv_next)
    );

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_win_top = r_win_top;
        n_win_mid = r_win_mid;
        rd_en     = 1'b0;
        rd_addr   = ROW_AW'(i_row_index);
        wr_en     = 1'b0;
        wr_addr   = r_row;
        wr_data   = (rd_row & ~(t_row'(1) << r_col)) | (t_row'(r_cell) << r_col);
        load      = 1'b0;
        load_cell = 1'b0;
        load_kind = r_cmd;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_command == CMD_WRITE || i_command == CMD_READ) && in_grid) begin
                        rd_en   = 1'b1;
                        n_state = S_ACCESS;
                    end else if (i_command == CMD_ADVANCE) begin
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                        n_step    = '0;
                        n_win_top = '0;
                        n_win_mid = '0;
                        n_state   = S_ADV;
                    end else begin
                        load      = 1'b1;
                        load_kind = i_command;
                    end
                end
            end
            S_ACCESS: begin
                load    = 1'b1;
                n_state = S_IDLE;
                if (r_cmd == CMD_WRITE) begin
                    wr_en = 1'b1;
                end else begin
                    load_cell = rd_row[r_col];
                end
            end
            S_ADV: begin
                if (r_step < STEP_W'(GRID_ROWS - 1)) begin
                    rd_en   = 1'b1;
                    rd_addr = ROW_AW'(r_step + STEP_W'(1));
                end
                if (r_step != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = ROW_AW'(r_step - STEP_W'(1));
                    wr_data = adv_next;
                end
                n_win_top = r_win_mid;
                n_win_mid = adv_below;
                n_step    = r_step + STEP_W'(1);
                if (r_step == STEP_W'(GRID_ROWS)) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_live  <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_row_live[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_win_top <= n_win_top;
        r_win_mid <= n_win_mid;
        if (accept) begin
            r_cmd  <= i_command;
            r_row  <= ROW_AW'(i_row_index);
            r_col  <= COL_AW'(i_col_index);
            r_cell <= i_cell_in;
        end
        if (load) begin
            r_out_cell <= load_cell;
            r_out_kind <= load_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_grid[rd_addr];
            r_rd_live <= r_row_live[rd_addr];
        end
        if (wr_en) begin
            r_grid[wr_addr] <= wr_data;
        end
    end

    `LGS_ASSERT_NOW(a_adv_no_overlap, i_clk, i_rst_n, (r_state == S_ADV) && wr_en && rd_en, wr_addr != rd_addr)
    `LGS_ASSERT_NEXT(a_adv_result, i_clk, i_rst_n, (r_state == S_ADV) && (r_step == STEP_W'(GRID_ROWS)), o_valid && (o_done_kind == CMD_ADVANCE) && !o_cell_out)
    `LGS_ASSERT_NOW(a_read_source, i_clk, i_rst_n, rd_en, accept || (r_state == S_ADV))

endmodule

@@ src/lgs_row_rule.sv @@
// Computes one new grid row under the B3/S23 rule from three old rows.
// Depends on lgs_pkg for the row type and the column count.
module lgs_row_rule import lgs_pkg::*; (
    input  t_row i_above,
    input  t_row i_mid,
    input  t_row i_below,
    output t_row o_next
);

    logic [GRID_COLS+1:0] pad_above;
    logic [GRID_COLS+1:0] pad_mid;
    logic [GRID_COLS+1:0] pad_below;

    assign pad_above = {1'b0, i_above, 1'b0};
    assign pad_mid   = {1'b0, i_mid, 1'b0};
    assign pad_below = {1'b0, i_below, 1'b0};

    always_comb begin
        logic [3:0] count;
        for (int c = 0; c < GRID_COLS; c++) begin
            count = 4'(pad_above[c]) + 4'(pad_above[c+1]) + 4'(pad_above[c+2])
                  + 4'(pad_mid[c]) + 4'(pad_mid[c+2])
                  + 4'(pad_below[c]) + 4'(pad_below[c+1]) + 4'(pad_below[c+2]);
            o_next[c] = (count == 4'd3) || (i_mid[c] && (count == 4'd2));
        end
    end

endmodule
